>>> hdl/lsc_pkg.sv
package lsc_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD_LAG   = 2'd0,
    REQ_LOAD_CARRY = 2'd1,
    REQ_GENERATE   = 2'd2
  } req_type_e;

  // published lags and carry step (step is for 24-bit fractions, reduced per width)
  localparam int unsigned SHORT_LAG = 33;
  localparam longint unsigned CARRY_STEP_BASE = 64'd7654321;

  // carry modulus offset below 2^fraction_bits
  localparam int unsigned CARRY_MOD_OFFSET = 3;

endpackage

>>> hdl/lsc_cell.sv
module lsc_cell #(
  parameter int unsigned FRACTION_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     shift_i,
  input  logic [FRACTION_BITS-1:0] word_i,
  output logic [FRACTION_BITS-1:0] word_o
);

  logic [FRACTION_BITS-1:0] word_q;
  logic [FRACTION_BITS-1:0] word_d;

  assign word_d = shift_i ? word_i : word_q;

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

>>> hdl/lsc_out_buf.sv
module lsc_out_buf #(
  parameter int unsigned WIDTH = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign pop     = valid_o && !stall_i;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/lagged_subtract_carry_rng.sv
// lagged subtract-with-carry uniform generator (lags LONG_LAG and 33)
// input channel: in_valid_i / in_stall_o with req_type_i and seed_word_i
//   load lag word  - shifts seed_word_i into the lag line as the newest word
//   load carry     - replaces the carry word
//   generate       - produces one random_fraction_o result
// output channel: out_valid_o / out_stall_i with random_fraction_o
// all LONG_LAG lag words must be loaded before the first generate request;
// the first lag word loaded becomes the oldest
// one request is taken per cycle while in_stall_o is low; the result of an
// accepted generate is registered in the output buffer behind any waiting results
// the lag words live in a line of LONG_LAG cells that all shift on each
// lag-word load or generate, so the two taps are fixed cells and no ring pointer exists
// results wait in a two-entry output buffer; in_stall_o rises only while
// both entries are held, so a stalled receiver stops intake after two results
// reset clears the carry and the output buffer; lag words stay undefined
module lagged_subtract_carry_rng #(
  parameter int unsigned LONG_LAG      = 97,
  parameter int unsigned FRACTION_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               req_type_i,
  input  logic [FRACTION_BITS-1:0] seed_word_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [FRACTION_BITS-1:0] random_fraction_o
);

  localparam int unsigned ShortLag = (lsc_pkg::SHORT_LAG < LONG_LAG) ?
                                     lsc_pkg::SHORT_LAG : LONG_LAG - 1;
  localparam longint unsigned CarryModFull =
    (64'd1 << FRACTION_BITS) - 64'(lsc_pkg::CARRY_MOD_OFFSET);
  localparam longint unsigned CarryStepFull = lsc_pkg::CARRY_STEP_BASE % CarryModFull;
  localparam logic [FRACTION_BITS-1:0] CarryStep = CarryStepFull[FRACTION_BITS-1:0];
  localparam logic [FRACTION_BITS-1:0] CarryWrap =
    FRACTION_BITS'(CarryModFull - CarryStepFull);

  logic                     accept;
  logic                     shift;
  logic                     gen;
  logic                     buf_full;
  logic [FRACTION_BITS-1:0] new_word;
  logic [FRACTION_BITS-1:0] lag_word [LONG_LAG];
  logic [FRACTION_BITS-1:0] carry_q, carry_d, carry_next;
  logic [FRACTION_BITS-1:0] diff_x;
  logic [FRACTION_BITS-1:0] result;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;
  assign gen        = accept && (req_type_i == lsc_pkg::REQ_GENERATE);
  assign shift      = gen || (accept && (req_type_i == lsc_pkg::REQ_LOAD_LAG));

  // cell 0 holds the newest word, the last cell the oldest
  assign diff_x   = lag_word[LONG_LAG-1] - lag_word[ShortLag-1];
  assign new_word = (req_type_i == lsc_pkg::REQ_GENERATE) ? diff_x : seed_word_i;

  for (genvar i = 0; i < LONG_LAG; i++) begin : g_cell
    lsc_cell #(
      .FRACTION_BITS(FRACTION_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .word_i ((i == 0) ? new_word : lag_word[(i == 0) ? 0 : i-1]),
      .word_o (lag_word[i])
    );
  end

  // carry steps down by a constant, wrapping modulo 2^n - 3
  assign carry_next = (carry_q >= CarryStep) ? (carry_q - CarryStep)
                                             : (carry_q + CarryWrap);
  assign result     = diff_x - carry_next;

  always_comb begin
    carry_d = carry_q;
    if (accept) begin
      case (req_type_i)
        lsc_pkg::REQ_LOAD_CARRY: carry_d = seed_word_i;
        lsc_pkg::REQ_GENERATE:   carry_d = carry_next;
        default:                 carry_d = carry_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  lsc_out_buf #(
    .WIDTH(FRACTION_BITS)
  ) u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (gen),
    .data_i (result),
    .full_o (buf_full),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (random_fraction_o)
  );

endmodule

>>> verif/lagged_subtract_carry_rng_checker.sv
module lagged_subtract_carry_rng_checker #(
  parameter int unsigned LONG_LAG      = 97,
  parameter int unsigned FRACTION_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [1:0]               req_type_i,
  input  logic [FRACTION_BITS-1:0] seed_word_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [FRACTION_BITS-1:0] random_fraction_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [FRACTION_BITS-1:0] fraction_t;

  localparam longint unsigned CARRY_MOD =
    (64'd1 << FRACTION_BITS) - lsc_pkg::CARRY_MOD_OFFSET;
  localparam fraction_t CARRY_STEP = fraction_t'(lsc_pkg::CARRY_STEP_BASE % CARRY_MOD);
  localparam fraction_t CARRY_WRAP = fraction_t'(CARRY_MOD - CARRY_STEP);
  // distance from the oldest word forward to the short-lag word
  localparam int unsigned TAP_GAP =
    (lsc_pkg::SHORT_LAG < LONG_LAG) ? LONG_LAG - lsc_pkg::SHORT_LAG : 1;

  fraction_t   lag_words [LONG_LAG];
  int unsigned oldest_slot;
  fraction_t   carry_word;
  fraction_t   fraction_queue [$];
  fraction_t   oldest_fraction;

  task automatic absorb_request(logic [1:0] kind, fraction_t word);
    int unsigned tap;
    fraction_t   mixed;
    tap = (oldest_slot + TAP_GAP) % LONG_LAG;
    case (kind)
      lsc_pkg::REQ_LOAD_LAG: begin
        lag_words[oldest_slot] = word;
        oldest_slot = (oldest_slot + 1) % LONG_LAG;
      end
      lsc_pkg::REQ_LOAD_CARRY: begin
        carry_word = word;
      end
      lsc_pkg::REQ_GENERATE: begin
        mixed = lag_words[oldest_slot] - lag_words[tap];
        lag_words[oldest_slot] = mixed;
        oldest_slot = (oldest_slot + 1) % LONG_LAG;
        // a loaded carry at or above the modulus still just drops by the step
        if (carry_word >= CARRY_STEP) begin
          carry_word = carry_word - CARRY_STEP;
        end else begin
          carry_word = carry_word + CARRY_WRAP;
        end
        fraction_queue.push_back(mixed - carry_word);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (lag_words[i]) lag_words[i] = '0;
      oldest_slot = 0;
      carry_word = '0;
      fraction_queue.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        absorb_request(req_type_i, seed_word_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (fraction_queue.size() == 0) begin
          $error("random_fraction: expected none, actual %h", random_fraction_i);
          fail_count_o++;
        end else begin
          oldest_fraction = fraction_queue.pop_front();
          if (random_fraction_i !== oldest_fraction) begin
            $error("random_fraction: expected %h, actual %h", oldest_fraction,
                   random_fraction_i);
            fail_count_o++;
          end
        end
      end
      pending_o = fraction_queue.size();
    end
  end

endmodule

>>> verif/lagged_subtract_carry_rng_test.sv
module lagged_subtract_carry_rng_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LONG_LAG        = 97;
  localparam int unsigned FRACTION_BITS   = 24;
  localparam logic [1:0]  REQ_UNUSED      = 2'd3;
  localparam int          RANDOM_REQUESTS = 1500;
  localparam int          CALM_REQUESTS   = 300;
  localparam int          HOLD_START      = 800;
  localparam int          HOLD_CYCLES     = 400;
  localparam int          DRAIN_CYCLES    = 10;
  localparam int          CYCLE_LIMIT     = 200000;

  typedef logic [FRACTION_BITS-1:0] fraction_t;

  localparam fraction_t ALL_ONES   = '1;
  localparam fraction_t CARRY_MOD  =
    fraction_t'((64'd1 << FRACTION_BITS) - lsc_pkg::CARRY_MOD_OFFSET);
  localparam fraction_t CARRY_STEP = fraction_t'(lsc_pkg::CARRY_STEP_BASE);

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] req_type;
  fraction_t  seed_word;
  logic       out_valid;
  logic       out_stall;
  fraction_t  random_fraction;
  int         check_failures;
  int         fractions_pending;
  bit         calm;
  bit         sender_bursts;
  int         cycle_count;

  lagged_subtract_carry_rng #(
    .LONG_LAG     (LONG_LAG),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .req_type_i       (req_type),
    .seed_word_i      (seed_word),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .random_fraction_o(random_fraction)
  );

  lagged_subtract_carry_rng_checker #(
    .LONG_LAG     (LONG_LAG),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .req_type_i       (req_type),
    .seed_word_i      (seed_word),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .random_fraction_i(random_fraction),
    .fail_count_o     (check_failures),
    .pending_o        (fractions_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(logic [1:0] kind, fraction_t word);
    if (!calm && sender_bursts && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = kind;
    seed_word = word;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lagged_subtract_carry_rng test failed");
    $finish;
  end

  // receiver: short stall bursts, calm stretches, and one long hold-off
  initial begin
    int  rx_cycles;
    bit  held;
    bit  stall_bursts;
    out_stall = 1'b0;
    rx_cycles = 0;
    held = 1'b0;
    stall_bursts = 1'b1;
    wait (rst_n);
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (!held && rx_cycles >= HOLD_START) begin
        held = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if (rx_cycles % 128 == 0) begin
        stall_bursts = ($urandom_range(0, 3) != 0);
      end else if (!calm && stall_bursts && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    fraction_t  word;
    logic [1:0] kind;
    int         pick;
    int         count;
    cycle_count = 0;
    calm = 1'b0;
    sender_bursts = 1'b1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    req_type = lsc_pkg::REQ_LOAD_LAG;
    seed_word = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // fill every lag word before any generate, extremes at the first slots
    for (int i = 0; i < LONG_LAG; i++) begin
      case (i)
        0:       word = '0;
        1:       word = ALL_ONES;
        2:       word = fraction_t'(1);
        3:       word = {1'b1, {(FRACTION_BITS-1){1'b0}}};
        default: word = fraction_t'($urandom());
      endcase
      send_request(lsc_pkg::REQ_LOAD_LAG, word);
    end

    // carry wrap from zero, carry at and above the modulus, carry around the step
    send_request(lsc_pkg::REQ_GENERATE, ALL_ONES);
    send_request(lsc_pkg::REQ_LOAD_CARRY, ALL_ONES);
    send_request(lsc_pkg::REQ_GENERATE, '0);
    send_request(lsc_pkg::REQ_LOAD_CARRY, CARRY_MOD);
    send_request(lsc_pkg::REQ_GENERATE, '0);
    send_request(lsc_pkg::REQ_LOAD_CARRY, CARRY_MOD - 1'b1);
    send_request(lsc_pkg::REQ_GENERATE, '0);
    send_request(lsc_pkg::REQ_LOAD_CARRY, CARRY_STEP);
    send_request(lsc_pkg::REQ_GENERATE, '0);
    send_request(lsc_pkg::REQ_LOAD_CARRY, CARRY_STEP - 1'b1);
    send_request(lsc_pkg::REQ_GENERATE, '0);
    send_request(REQ_UNUSED, ALL_ONES);
    send_request(lsc_pkg::REQ_GENERATE, '0);
    send_request(lsc_pkg::REQ_LOAD_LAG, '0);
    send_request(lsc_pkg::REQ_LOAD_LAG, ALL_ONES);
    send_request(lsc_pkg::REQ_GENERATE, '0);
    send_request(lsc_pkg::REQ_GENERATE, '0);
    send_request(lsc_pkg::REQ_LOAD_CARRY, '0);
    send_request(lsc_pkg::REQ_GENERATE, '0);

    count = 0;
    while (count < RANDOM_REQUESTS) begin
      calm = (count >= RANDOM_REQUESTS - CALM_REQUESTS);
      if (count % 64 == 0) begin
        sender_bursts = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 7))
        0:       word = ALL_ONES;
        1:       word = '0;
        default: word = fraction_t'($urandom());
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        kind = lsc_pkg::REQ_GENERATE;
      end else if (pick < 85) begin
        kind = lsc_pkg::REQ_LOAD_LAG;
      end else if (pick < 95) begin
        kind = lsc_pkg::REQ_LOAD_CARRY;
      end else begin
        kind = REQ_UNUSED;
      end
      send_request(kind, word);
      if (kind != REQ_UNUSED) begin
        count++;
      end
    end
    in_valid = 1'b0;

    wait (fractions_pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (check_failures == 0 && fractions_pending == 0) begin
      $display("lagged_subtract_carry_rng test passed");
    end else begin
      $display("lagged_subtract_carry_rng test failed");
    end
    $finish;
  end

endmodule
